// ===== rtl/core/furl_pkg.sv =====
// ----------------------------------------------------------------------------
// furl_pkg
// shared types and constants of the upload rate limiter
// ----------------------------------------------------------------------------
package furl_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned WriterBitsDef = 8;

  localparam int unsigned RateW   = 24;
  localparam int unsigned BytesW  = 16;
  localparam int unsigned MsW     = 16;
  localparam int unsigned CreditW = 32;
  localparam int unsigned IdW     = 8;
  localparam int unsigned RemW    = 5;

  localparam logic [1:0] FUNC_REQ  = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_KILL = 2'd2;

  localparam logic [1:0] KIND_DECISION = 2'd0;
  localparam logic [1:0] KIND_GRANT    = 2'd1;
  localparam logic [1:0] KIND_IDLE     = 2'd2;
  localparam logic [1:0] KIND_KILL_ACK = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [IdW-1:0]    writer_id;
    logic [BytesW-1:0] packet_bytes;
    logic [MsW-1:0]    elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IdW-1:0]    grant_writer;
    logic [BytesW-1:0] grant_bytes;
    logic              passed;
    logic              queue_full;
    logic [RemW-1:0]   removed_count;
    logic              last;
  } out_item_t;

  // command from the controller to every cell of the row
  typedef struct packed {
    logic push;    // write the tail slot
    logic pop;     // all cells take their right neighbor
    logic trim;    // head slot loses bytes
    logic kill;    // compaction step: selected cells take their right neighbor
  } cell_cmd_t;

endpackage

// ===== rtl/core/furl_if.sv =====
// ----------------------------------------------------------------------------
// furl_if
// valid/ready channel carrying one word of payload type
// ----------------------------------------------------------------------------
interface furl_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/fifo_upload_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// fifo_upload_rate_limiter
// token-bucket byte shaper with a queue of pending sends
// ----------------------------------------------------------------------------
// Channels: in_if carries func, writer_id, packet_bytes, elapsed_ms; out_if
// carries kind, grant_writer, grant_bytes, passed, queue_full,
// removed_count, last. cfg_if writes the 24-bit rate; write it only while
// the block is idle. One item is worked at a time.
// A send request passes through the output state, which registers its
// decision. A tick works out the credit in the states MUL (operand wait),
// DIV and DIV2 (two half-width multiplies by the reciprocal of 1000) and
// FIX (the correction), then gives one grant per cycle while the receiver
// takes them. A tick on an empty queue gives an idle word from MUL. A kill
// walks the queued cells once, one per cycle, then gives its acknowledge.
// The row of cells shifts toward the head on each full grant, so the head
// is always cell 0. Reset empties the queue and clears the leftover credit
// and the rate. When the receiver stalls, the result waits in the output
// register and the sequencer holds; the next input is taken once the item
// is done and its result word has been taken.
// ----------------------------------------------------------------------------
module fifo_upload_rate_limiter #(
  parameter int unsigned QueueDepth = furl_pkg::QueueDepthDef,
  parameter int unsigned WriterBits = furl_pkg::WriterBitsDef
) (
  input logic clk_i,
  input logic rst_ni,
  furl_if.sink   in_if,
  furl_if.sink   cfg_if,
  furl_if.source out_if
);
  import furl_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  // floor(2^40 / 1000): the quotient comes out exact or one low
  localparam logic [30:0] RecipK = 31'd1099511627;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIX  = 3'd3;
  localparam logic [2:0] ST_GR   = 3'd4;
  localparam logic [2:0] ST_KILL = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;
  localparam logic [2:0] ST_DIV2 = 3'd7;

  logic [2:0]         st_q, st_d;
  logic [RateW-1:0]   rate_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CreditW-1:0] left_q, left_d;
  logic [CreditW-1:0] credit_q, credit_d;
  in_item_t           it_q;
  logic [39:0]        prod_q;
  logic [39:0]        quot_q, quot_d;
  logic [CntW-1:0]    kidx_q, kidx_d;   // kill scan position
  logic [CntW-1:0]    kw_q, kw_d;       // kill write position
  logic [RemW-1:0]    krem_q, krem_d;
  logic               ngr_q, ngr_d;     // any grant given in this tick
  out_item_t          ob_q, ob_d;
  logic               ov_q, ov_d;

  cell_cmd_t            cmd;
  logic [WriterBits-1:0] cw [QueueDepth];
  logic [BytesW-1:0]     cb [QueueDepth];
  logic [WriterBits-1:0] in_wr;
  logic [BytesW-1:0]     trim_amt;
  logic [QueueDepth-1:0] ksel;

  assign in_wr = it_q.writer_id[WriterBits-1:0];

  // the row of cells
  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    logic [WriterBits-1:0] nbw;
    logic [BytesW-1:0]     nbb;
    if (g == QueueDepth - 1) begin : g_end
      assign nbw = cw[g];
      assign nbb = cb[g];
    end else begin : g_mid
      assign nbw = cw[g+1];
      assign nbb = cb[g+1];
    end
    // compaction: cells from the write position up shift once per hit
    assign ksel[g] = (CntW'(g) >= kw_q);
    furl_cell #(.WriterBits(WriterBits)) u_cell (
      .clk_i, .rst_ni, .cmd_i(cmd),
      .is_tail_i(cnt_q == CntW'(g)),
      .is_head_i(g == 0),
      .kill_sel_i(ksel[g]),
      .push_writer_i(in_wr),
      .push_bytes_i(it_q.packet_bytes),
      .trim_bytes_i(trim_amt),
      .nb_writer_i(nbw),
      .nb_bytes_i(nbb),
      .writer_o(cw[g]),
      .bytes_o(cb[g])
    );
  end

  // kill compares the cell at the write position; after a hit the
  // remaining cells move down so the same position is tested again
  logic [IdxW-1:0] kw_idx;
  logic            khit;
  assign kw_idx = kw_q[IdxW-1:0];
  assign khit   = (cw[kw_idx] == in_wr);

  logic [CreditW-1:0] need32;
  logic [CreditW:0]   sum;
  logic [39:0]        rem;
  logic [39:0]        quot_fix;
  assign need32 = CreditW'(cb[0]);
  assign trim_amt = credit_q[BytesW-1:0];
  assign rem = prod_q - quot_q * 40'd1000;
  assign quot_fix = (rem >= 40'd1000) ? quot_q + 40'd1 : quot_q;

  assign in_if.ready  = (st_q == ST_IDLE) && !ov_q;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = ov_q;
  assign out_if.data  = ob_q;

  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    credit_d = credit_q;
    quot_d   = quot_q;
    kidx_d   = kidx_q;
    kw_d     = kw_q;
    krem_d   = krem_q;
    ngr_d    = ngr_q;
    ob_d     = ob_q;
    ov_d     = ov_q && !out_if.ready;
    cmd      = '0;
    sum      = '0;
    case (st_q)
      ST_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          case (in_if.data.func)
            FUNC_REQ:  st_d = ST_OUT;
            FUNC_TICK: st_d = ST_MUL;
            FUNC_KILL: begin
              st_d = ST_KILL;
              kidx_d = '0;
              kw_d = '0;
              krem_d = '0;
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_OUT: begin
        ob_d = '0;
        ob_d.kind = KIND_DECISION;
        ob_d.grant_writer = IdW'(in_wr);
        ob_d.last = 1'b1;
        if (rate_q == '0) begin
          ob_d.grant_bytes = it_q.packet_bytes;
          ob_d.passed = 1'b1;
        end else if (cnt_q < CntW'(QueueDepth)) begin
          cmd.push = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end else begin
          ob_d.queue_full = 1'b1;
        end
        ov_d = 1'b1;
        st_d = ST_IDLE;
      end
      ST_MUL: begin
        if (cnt_q == '0) begin
          ob_d = '0;
          ob_d.kind = KIND_IDLE;
          ob_d.last = 1'b1;
          ov_d = 1'b1;
          st_d = ST_IDLE;
        end else begin
          st_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // low half of the product times the reciprocal, scaled by 2^-20
        quot_d = 40'((51'(prod_q[19:0]) * 51'(RecipK)) >> 20);
        st_d = ST_DIV2;
      end
      ST_DIV2: begin
        // high half joins the low partial, estimate fixed in the next cycle
        quot_d = 40'((52'(prod_q[39:20]) * 52'(RecipK) + 52'(quot_q)) >> 20);
        st_d = ST_FIX;
      end
      ST_FIX: begin
        sum = (CreditW+1)'(quot_fix) + (CreditW+1)'(left_q);
        if (quot_fix > 40'hFFFF_FFFF || sum[CreditW])
          credit_d = '1;
        else
          credit_d = sum[CreditW-1:0];
        ngr_d = 1'b0;
        st_d = ST_GR;
      end
      ST_GR: begin
        if (!ov_q || out_if.ready) begin
          if (cnt_q == '0 || credit_q == '0) begin
            left_d = credit_q;
            if (!ngr_q) begin
              ob_d = '0;
              ob_d.kind = KIND_IDLE;
              ob_d.last = 1'b1;
              ov_d = 1'b1;
            end
            st_d = ST_IDLE;
          end else begin
            ob_d = '0;
            ob_d.kind = KIND_GRANT;
            ob_d.grant_writer = IdW'(cw[0]);
            ngr_d = 1'b1;
            if (need32 <= credit_q) begin
              ob_d.grant_bytes = cb[0];
              credit_d = credit_q - need32;
              cmd.pop = 1'b1;
              cnt_d = cnt_q - 1'b1;
              ob_d.last = (cnt_q == CntW'(1)) || (credit_q == need32);
            end else begin
              ob_d.grant_bytes = trim_amt;
              cmd.trim = 1'b1;
              credit_d = '0;
              ob_d.last = 1'b1;
            end
            ov_d = 1'b1;
          end
        end
      end
      ST_KILL: begin
        if (kidx_q == cnt_q) begin
          if (!ov_q || out_if.ready) begin
            cnt_d = kw_q;
            ob_d = '0;
            ob_d.kind = KIND_KILL_ACK;
            ob_d.grant_writer = IdW'(in_wr);
            ob_d.removed_count = krem_q;
            ob_d.last = 1'b1;
            ov_d = 1'b1;
            st_d = ST_IDLE;
          end
        end else begin
          kidx_d = kidx_q + 1'b1;
          if (khit) begin
            cmd.kill = 1'b1;
            krem_d = krem_q + 1'b1;
          end else begin
            kw_d = kw_q + 1'b1;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      left_q <= '0;
      rate_q <= '0;
      ov_q   <= 1'b0;
      kidx_q <= '0;
      kw_q   <= '0;
      krem_q <= '0;
      ngr_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      left_q <= left_d;
      ov_q   <= ov_d;
      kidx_q <= kidx_d;
      kw_q   <= kw_d;
      krem_q <= krem_d;
      ngr_q  <= ngr_d;
      if (cfg_if.valid) begin
        rate_q <= cfg_if.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      it_q <= in_if.data;
    end
    prod_q   <= 40'(it_q.elapsed_ms) * 40'(rate_q);
    quot_q   <= quot_d;
    credit_q <= credit_d;
    ob_q     <= ob_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(QueueDepth))
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FIX) |-> (rem < 40'd2000))
    else $error("reciprocal quotient off by more than one");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !ov_q)
    else $error("input taken while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push || cmd.kill) |-> !cmd.pop)
    else $error("conflicting cell commands");
endmodule

// ===== rtl/core/furl_cell.sv =====
// ----------------------------------------------------------------------------
// furl_cell
// one queue slot: holds a writer and its remaining bytes, shifts left
// ----------------------------------------------------------------------------
module furl_cell #(
  parameter int unsigned WriterBits = furl_pkg::WriterBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  furl_pkg::cell_cmd_t        cmd_i,
  input  logic                       is_tail_i,   // this slot is the push target
  input  logic                       is_head_i,
  input  logic                       kill_sel_i,  // compaction step shifts this slot
  input  logic [WriterBits-1:0]      push_writer_i,
  input  logic [furl_pkg::BytesW-1:0] push_bytes_i,
  input  logic [furl_pkg::BytesW-1:0] trim_bytes_i,
  input  logic [WriterBits-1:0]      nb_writer_i,
  input  logic [furl_pkg::BytesW-1:0] nb_bytes_i,
  output logic [WriterBits-1:0]      writer_o,
  output logic [furl_pkg::BytesW-1:0] bytes_o
);
  import furl_pkg::*;

  logic [WriterBits-1:0] writer_q, writer_d;
  logic [BytesW-1:0]     bytes_q, bytes_d;

  always_comb begin
    writer_d = writer_q;
    bytes_d  = bytes_q;
    if (cmd_i.push && is_tail_i) begin
      writer_d = push_writer_i;
      bytes_d  = push_bytes_i;
    end else if (cmd_i.pop || (cmd_i.kill && kill_sel_i)) begin
      writer_d = nb_writer_i;
      bytes_d  = nb_bytes_i;
    end else if (cmd_i.trim && is_head_i) begin
      bytes_d = bytes_q - trim_bytes_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      writer_q <= '0;
      bytes_q  <= '0;
    end else begin
      writer_q <= writer_d;
      bytes_q  <= bytes_d;
    end
  end

  assign writer_o = writer_q;
  assign bytes_o  = bytes_q;
endmodule

// ===== dv/furl_checker.sv =====
// ----------------------------------------------------------------------------
// furl_checker
// watches the rate limiter channels, predicts each result word and compares
// ----------------------------------------------------------------------------
module furl_checker
  import furl_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [23:0] cfg_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          grant_count_o,
  output int          full_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [RateW-1:0]   rate_q;
  logic [IdW-1:0]     q_writer[$];
  logic [BytesW-1:0]  q_bytes[$];
  logic [CreditW-1:0] leftover_q;
  out_item_t          expected_words[$];

  function automatic out_item_t mk(logic [1:0] kind, logic [IdW-1:0] wr,
                                   logic [BytesW-1:0] bytes, logic pass,
                                   logic full, logic [RemW-1:0] rem,
                                   logic lst);
    out_item_t o;
    o.kind = kind; o.grant_writer = wr; o.grant_bytes = bytes; o.passed = pass;
    o.queue_full = full; o.removed_count = rem; o.last = lst;
    return o;
  endfunction

  task automatic shape_item(input in_item_t it);
    logic [63:0]        fresh;
    logic [63:0]        sum;
    logic [CreditW-1:0] credit;
    int                 n;
    int                 removed;
    logic [IdW-1:0]     kw[$];
    logic [BytesW-1:0]  kb[$];
    n = 0;
    removed = 0;
    case (it.func)
      FUNC_REQ: begin
        if (rate_q == '0) begin
          expected_words.push_back(mk(KIND_DECISION, it.writer_id, it.packet_bytes,
                                      1'b1, 1'b0, '0, 1'b1));
        end else if (q_writer.size() < QueueDepth) begin
          q_writer.push_back(it.writer_id);
          q_bytes.push_back(it.packet_bytes);
          expected_words.push_back(mk(KIND_DECISION, it.writer_id, '0, 1'b0, 1'b0,
                                      '0, 1'b1));
        end else begin
          full_count_o++;
          expected_words.push_back(mk(KIND_DECISION, it.writer_id, '0, 1'b0, 1'b1,
                                      '0, 1'b1));
        end
      end
      FUNC_TICK: begin
        if (q_writer.size() == 0) begin
          expected_words.push_back(mk(KIND_IDLE, '0, '0, 1'b0, 1'b0, '0, 1'b1));
        end else begin
          fresh = (64'(it.elapsed_ms) * 64'(rate_q)) / 64'd1000;
          sum = fresh + 64'(leftover_q);
          credit = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
          while (q_writer.size() > 0 && credit > 0) begin
            if (32'(q_bytes[0]) <= credit) begin
              credit -= 32'(q_bytes[0]);
              expected_words.push_back(mk(KIND_GRANT, q_writer[0], q_bytes[0],
                                          1'b0, 1'b0, '0, 1'b0));
              q_writer.delete(0);
              q_bytes.delete(0);
            end else begin
              expected_words.push_back(mk(KIND_GRANT, q_writer[0], credit[15:0],
                                          1'b0, 1'b0, '0, 1'b0));
              q_bytes[0] = q_bytes[0] - credit[15:0];
              credit = '0;
            end
            n++;
          end
          leftover_q = credit;
          grant_count_o += n;
          if (n == 0) begin
            expected_words.push_back(mk(KIND_IDLE, '0, '0, 1'b0, 1'b0, '0, 1'b1));
          end else begin
            expected_words[expected_words.size()-1].last = 1'b1;
          end
        end
      end
      FUNC_KILL: begin
        foreach (q_writer[i]) begin
          if (q_writer[i] == it.writer_id) begin
            removed++;
          end else begin
            kw.push_back(q_writer[i]);
            kb.push_back(q_bytes[i]);
          end
        end
        q_writer = kw;
        q_bytes = kb;
        expected_words.push_back(mk(KIND_KILL_ACK, it.writer_id, '0, 1'b0, 1'b0,
                                    RemW'(removed), 1'b1));
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      rate_q <= '0;
      leftover_q = '0;
      q_writer.delete();
      q_bytes.delete();
      expected_words.delete();
      fail_count_o <= 0;
      grant_count_o <= 0;
      full_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) rate_q <= cfg_data_i;
      if (in_valid_i && in_ready_i) shape_item(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_words[0];
          expected_words.delete(0);
          if (out_data_i !== e) begin
            fail_count_o <= fail_count_o + 1;
            if (out_data_i.kind !== e.kind)
              $error("kind expected %0d got %0d", e.kind, out_data_i.kind);
            if (out_data_i.grant_writer !== e.grant_writer)
              $error("grant_writer expected %0d got %0d", e.grant_writer,
                     out_data_i.grant_writer);
            if (out_data_i.grant_bytes !== e.grant_bytes)
              $error("grant_bytes expected %0d got %0d", e.grant_bytes,
                     out_data_i.grant_bytes);
            if (out_data_i.passed !== e.passed)
              $error("passed expected %0d got %0d", e.passed, out_data_i.passed);
            if (out_data_i.queue_full !== e.queue_full)
              $error("queue_full expected %0d got %0d", e.queue_full,
                     out_data_i.queue_full);
            if (out_data_i.removed_count !== e.removed_count)
              $error("removed_count expected %0d got %0d", e.removed_count,
                     out_data_i.removed_count);
            if (out_data_i.last !== e.last)
              $error("last expected %0d got %0d", e.last, out_data_i.last);
          end
        end
      end
    end
  end

  assign pending_o = expected_words.size();
endmodule

// ===== dv/fifo_upload_rate_limiter_test.sv =====
// ----------------------------------------------------------------------------
// fifo_upload_rate_limiter_test
// drives requests, ticks and kills under several rates and idling phases;
// a checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module fifo_upload_rate_limiter_test;
  import furl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned InW = $bits(in_item_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, grant_count, full_count;
  int   sender_idle_pct = 0, receiver_stall_pct = 0;
  bit   hold_off = 0;
  int   quiet_cycles = 0;
  int   items_sent = 0;

  always #5ns clk_i = ~clk_i;

  furl_if #(.payload_t(in_item_t))    in_if ();
  furl_if #(.payload_t(out_item_t))   out_if ();
  furl_if #(.payload_t(logic [23:0])) cfg_if ();

  fifo_upload_rate_limiter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .cfg_if (cfg_if.sink),
    .out_if (out_if.source)
  );

  furl_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_ready_i    (in_if.ready),
    .in_data_i     (in_if.data),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_ready_i   (cfg_if.ready),
    .cfg_data_i    (cfg_if.data),
    .out_valid_i   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .out_data_i    (out_if.data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .grant_count_o (grant_count),
    .full_count_o  (full_count)
  );

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
  end

  // receiver stalls at random, or holds off for a long stretch
  always @(posedge clk_i) begin
    out_if.ready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(input in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    in_if.valid <= 1'b0;
    items_sent++;
    @(posedge clk_i);
  endtask

  task automatic send_fields(input logic [1:0] f, input logic [7:0] wr,
                             input logic [15:0] b, input logic [15:0] ms);
    in_item_t it;
    it.func = f; it.writer_id = wr; it.packet_bytes = b; it.elapsed_ms = ms;
    send_word(it);
  endtask

  task automatic drain_results();
    while (pending != 0) @(posedge clk_i);
    repeat (QueueDepthDef + 8) @(posedge clk_i);
  endtask

  task automatic set_rate(input logic [23:0] rate);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= rate;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly requests from a few writers, ticks and kills mixed in
  task automatic random_traffic(input int count);
    int       sel;
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      it = in_item_t'(InW'({$urandom, $urandom}));
      if ($urandom_range(3) != 0) it.writer_id = 8'($urandom_range(5));
      if ($urandom_range(3) != 0) it.packet_bytes = 16'($urandom_range(3000));
      if ($urandom_range(3) != 0) it.elapsed_ms = 16'($urandom_range(200));
      if (sel < 55) it.func = FUNC_REQ;
      else if (sel < 82) it.func = FUNC_TICK;
      else if (sel < 95) it.func = FUNC_KILL;
      else it.func = 2'd3;
      send_word(it);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rate zero: pass-through, tick on empty queue, unknown func, kill on empty queue
    send_fields(FUNC_REQ, 8'hFF, 16'hFFFF, 16'h0);
    send_fields(FUNC_REQ, 8'h00, 16'h0000, 16'hFFFF);
    send_fields(FUNC_TICK, 8'h00, 16'h0, 16'hFFFF);
    send_fields(2'd3, 8'hAA, 16'h5555, 16'hAAAA);
    send_fields(FUNC_KILL, 8'h7, 16'h0, 16'h0);

    set_rate(24'd1000);
    send_fields(FUNC_REQ, 8'd1, 16'd0, 16'd0);
    send_fields(FUNC_REQ, 8'd2, 16'd500, 16'd0);
    send_fields(FUNC_REQ, 8'd1, 16'd300, 16'd0);
    send_fields(FUNC_REQ, 8'd3, 16'hFFFF, 16'd0);
    send_fields(FUNC_TICK, 8'd0, 16'd0, 16'd0);       // zero credit
    send_fields(FUNC_TICK, 8'd0, 16'd0, 16'd700);     // partial grant
    send_fields(FUNC_KILL, 8'd1, 16'd0, 16'd0);
    send_fields(FUNC_KILL, 8'd9, 16'd0, 16'd0);       // absent writer
    for (int i = 0; i < 17; i++) send_fields(FUNC_REQ, 8'd4, 16'd10, 16'd0);
    drain_results();

    set_rate(24'hFFFFFF);
    send_fields(FUNC_TICK, 8'd0, 16'd0, 16'hFFFF);    // empties queue, big leftover
    send_fields(FUNC_REQ, 8'd5, 16'd1, 16'd0);
    send_fields(FUNC_TICK, 8'd0, 16'd0, 16'hFFFF);    // credit adds to the big leftover

    // rate zero: a tick on the empty queue gives an idle word
    set_rate(24'd0);
    send_fields(FUNC_TICK, 8'd0, 16'd0, 16'd5);

    set_rate(24'd1);
    send_fields(FUNC_REQ, 8'd6, 16'd0, 16'd0);
    send_fields(FUNC_TICK, 8'd0, 16'd0, 16'd999);

    // phases of idling, rate changed between them
    set_rate(24'd20000);
    random_traffic(40);
    sender_idle_pct = 70;
    set_rate(24'd1);
    random_traffic(40);
    sender_idle_pct = 0;
    receiver_stall_pct = 70;
    set_rate(24'd123457);
    random_traffic(40);
    sender_idle_pct = 36;
    receiver_stall_pct = 36;
    set_rate(24'hFFFFFF);
    random_traffic(40);

    // long receiver hold-off while requests keep coming
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    set_rate(24'd5000);
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      random_traffic(25);
    join
    drain_results();
    set_rate(24'd0);
    random_traffic(25);
    set_rate(24'd777);
    random_traffic(25);

    drain_results();
    $display("sent %0d items; %0d grant words, %0d full-queue drops checked",
             items_sent, grant_count, full_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
